// File: rtl/core/ipv4fa_pkg.sv
// ----------------------------------------------------------------------------
// ipv4fa_pkg
// Shared types and constants of the IPv4 forwarding block with address cache.
// ----------------------------------------------------------------------------
package ipv4fa_pkg;

    localparam int EntriesPerPort = 16;

    localparam logic [2:0] CfgPort0Addr  = 3'd0;
    localparam logic [2:0] CfgPort1Addr  = 3'd1;
    localparam logic [2:0] CfgPort0Mask  = 3'd2;
    localparam logic [2:0] CfgPort1Mask  = 3'd3;
    localparam logic [2:0] CfgPort0Mac   = 3'd4;
    localparam logic [2:0] CfgPort1Mac   = 3'd5;
    localparam logic [2:0] CfgDefRoute   = 3'd6;
    localparam logic [2:0] CfgGateway    = 3'd7;

    localparam logic [1:0] KindArp   = 2'd0;
    localparam logic [1:0] KindIpv4  = 2'd1;
    localparam logic [1:0] KindOther = 2'd2;
    localparam logic [1:0] KindRsvd  = 2'd3;

    localparam logic [1:0] ActNone    = 2'd0;
    localparam logic [1:0] ActArpRep  = 2'd1;
    localparam logic [1:0] ActArpReq  = 2'd2;
    localparam logic [1:0] ActForward = 2'd3;

    localparam logic [2:0] DropNone    = 3'd0;
    localparam logic [2:0] DropUnsupp  = 3'd1;
    localparam logic [2:0] DropNoRoute = 3'd2;
    localparam logic [2:0] DropHairpin = 3'd3;
    localparam logic [2:0] DropTtl     = 3'd4;
    localparam logic [2:0] DropArp     = 3'd5;

    localparam logic [1:0] RouteP0 = 2'd1;
    localparam logic [1:0] RouteP1 = 2'd2;

    typedef struct packed {
        logic        in_port;
        logic [1:0]  frame_kind;
        logic        arp_is_request;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [47:0] frame_src_mac;
        logic [47:0] arp_sender_mac;
        logic [7:0]  ttl;
        logic [15:0] header_checksum;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  drop_reason;
        logic        tx_port;
        logic [47:0] dst_mac_out;
        logic [47:0] src_mac_out;
        logic [31:0] arp_sender_ip_out;
        logic [31:0] arp_target_ip_out;
        logic [47:0] arp_target_mac_out;
        logic [7:0]  ttl_out;
        logic [15:0] checksum_out;
    } t_out_beat;

    // Token that travels down the chain of cache cells.
    typedef struct packed {
        logic        learn;     // learn ip/mac into this port
        logic        look;      // look up look_ip
        logic        learn_done;
        logic        hit;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] look_ip;
        logic [47:0] look_mac;
    } t_chain;

    typedef enum logic [1:0] {
        StIdle,
        StLearn,
        StLook,
        StOut
    } t_state;

endpackage

// File: rtl/core/ipv4fa_cell.sv
// ----------------------------------------------------------------------------
// ipv4fa_cell
// One cache entry. Learns and looks up as the token passes it.
// ----------------------------------------------------------------------------
module ipv4fa_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_over,   // chain found no match and claims this cell for the new entry
    input  ipv4fa_pkg::t_chain  i_tok,
    output ipv4fa_pkg::t_chain  o_tok,
    output logic                o_valid
);
    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic        w_match;
    logic        w_write;

    assign w_match = r_valid && (r_ip == i_tok.ip);
    assign o_valid = r_valid;

    always_comb begin
        o_tok = i_tok;
        w_write = 1'b0;
        if (i_tok.learn && !i_tok.learn_done) begin
            if (w_match) begin
                w_write = 1'b1;
                o_tok.learn_done = 1'b1;
            end
        end
        if (i_tok.look && r_valid && r_ip == i_tok.look_ip && !i_tok.hit) begin
            o_tok.hit = 1'b1;
            o_tok.look_mac = r_mac;
        end
    end

    // Learning works in two sweeps: the combinational chain finds a match
    // first; a free or overwrite claim is resolved by the enclosing chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step && (w_write || i_over)) begin
            r_valid <= 1'b1;
        end
        if (i_step && (w_write || i_over)) begin
            r_ip  <= i_tok.ip;
            r_mac <= i_tok.mac;
        end
    end
endmodule

// File: rtl/core/ipv4fa_chain.sv
// ----------------------------------------------------------------------------
// ipv4fa_chain
// The cache cells of one port, with slot claim for new entries.
// ----------------------------------------------------------------------------
module ipv4fa_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  ipv4fa_pkg::t_chain  i_tok,
    output ipv4fa_pkg::t_chain  o_tok
);
    localparam int N = ipv4fa_pkg::EntriesPerPort;

    ipv4fa_pkg::t_chain w_tok [N+1];
    logic [N-1:0] w_valid;
    logic [N-1:0] w_claim;
    logic         w_miss;

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < N; g++) begin : g_cell
        ipv4fa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (i_step),
            .i_over  (w_claim[g]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_valid (w_valid[g])
        );
    end

    assign w_miss = i_tok.learn && !w_tok[N].learn_done;

    // First free cell, else cell 0.
    always_comb begin
        logic found;
        found = 1'b0;
        w_claim = '0;
        for (int k = 0; k < N; k++) begin
            if (!w_valid[k] && !found) begin
                w_claim[k] = w_miss;
                found = 1'b1;
            end
        end
        if (!found) begin
            w_claim[0] = w_miss;
        end
    end

    assign o_tok = w_tok[N];
endmodule

// File: rtl/core/ipv4_forward_arp_cache.sv
// ----------------------------------------------------------------------------
// ipv4_forward_arp_cache
// Two-port IPv4 forwarding front end with a per-port IP-to-MAC cache.
// ----------------------------------------------------------------------------
// An accepted beat is held; the cache is learned in StLearn and searched in
// StLook, each pass through the row of cache cells. The result is held in
// StOut until taken; no new header is accepted before the block is idle.
// Reset clears all cache entries at once and defaults the config registers.
module ipv4_forward_arp_cache (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ipv4fa_pkg::t_in_beat   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ipv4fa_pkg::t_out_beat  o_out_data,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [47:0]            i_cfg_data
);
    logic [31:0] r_addr0, r_addr1, r_mask0, r_mask1, r_gw;
    logic [47:0] r_hw0, r_hw1;
    logic [1:0]  r_defrt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr0 <= '0; r_addr1 <= '0;
            r_mask0 <= 32'hFFFF_FF00; r_mask1 <= 32'hFFFF_FF00;
            r_hw0 <= '0; r_hw1 <= '0; r_defrt <= '0; r_gw <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ipv4fa_pkg::CfgPort0Addr: r_addr0 <= i_cfg_data[31:0];
                ipv4fa_pkg::CfgPort1Addr: r_addr1 <= i_cfg_data[31:0];
                ipv4fa_pkg::CfgPort0Mask: r_mask0 <= i_cfg_data[31:0];
                ipv4fa_pkg::CfgPort1Mask: r_mask1 <= i_cfg_data[31:0];
                ipv4fa_pkg::CfgPort0Mac:  r_hw0   <= i_cfg_data;
                ipv4fa_pkg::CfgPort1Mac:  r_hw1   <= i_cfg_data;
                ipv4fa_pkg::CfgDefRoute:  r_defrt <= i_cfg_data[1:0];
                ipv4fa_pkg::CfgGateway:   r_gw    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    ipv4fa_pkg::t_state r_state, n_state;
    ipv4fa_pkg::t_in_beat r_in;
    ipv4fa_pkg::t_out_beat r_out, n_out;
    ipv4fa_pkg::t_chain w_tok_in [2];
    ipv4fa_pkg::t_chain w_tok_out [2];
    logic [1:0] w_step;

    // Routing decision, settled from the held beat.
    logic       w_route_ok, w_op;
    logic [31:0] w_nh_ip;
    always_comb begin
        w_route_ok = 1'b1;
        w_op = 1'b0;
        w_nh_ip = r_in.dst_ip;
        if ((r_in.dst_ip & r_mask0) == (r_addr0 & r_mask0)) begin
            w_op = 1'b0;
        end else if ((r_in.dst_ip & r_mask1) == (r_addr1 & r_mask1)) begin
            w_op = 1'b1;
        end else if (r_defrt == ipv4fa_pkg::RouteP0 || r_defrt == ipv4fa_pkg::RouteP1) begin
            w_op = r_defrt[1];
            w_nh_ip = r_gw;
        end else begin
            w_route_ok = 1'b0;
        end
    end

    logic w_is_arp, w_is_ip, w_learn;
    assign w_is_arp = r_in.frame_kind == ipv4fa_pkg::KindArp;
    assign w_is_ip  = r_in.frame_kind == ipv4fa_pkg::KindIpv4;
    assign w_learn  = w_is_arp || w_is_ip;

    for (genvar p = 0; p < 2; p++) begin : g_port
        always_comb begin
            w_tok_in[p] = '0;
            w_tok_in[p].ip = r_in.src_ip;
            w_tok_in[p].mac = w_is_arp ? r_in.arp_sender_mac : r_in.frame_src_mac;
            w_tok_in[p].look_ip = w_nh_ip;
            w_tok_in[p].learn = (r_state == ipv4fa_pkg::StLearn) && w_learn
                                && (r_in.in_port == 1'(p));
            w_tok_in[p].look = (r_state == ipv4fa_pkg::StLook) && (w_op == 1'(p));
        end
        assign w_step[p] = r_state == ipv4fa_pkg::StLearn;
        ipv4fa_chain u_chain (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (w_step[p]),
            .i_tok   (w_tok_in[p]),
            .o_tok   (w_tok_out[p])
        );
    end

    // Result formation during the lookup cycle.
    logic [15:0] w_ck;
    always_comb begin
        logic [16:0] s;
        s = {1'b0, ~r_in.header_checksum} + 17'h0FEFF;
        s = {1'b0, s[15:0]} + {16'b0, s[16]};
        s = {1'b0, s[15:0]} + {16'b0, s[16]};
        w_ck = ~s[15:0];
    end

    always_comb begin
        logic [31:0] own_ip_in, own_ip_op;
        logic [47:0] own_mac_in, own_mac_op;
        own_ip_in  = r_in.in_port ? r_addr1 : r_addr0;
        own_mac_in = r_in.in_port ? r_hw1 : r_hw0;
        own_ip_op  = w_op ? r_addr1 : r_addr0;
        own_mac_op = w_op ? r_hw1 : r_hw0;
        n_out = '0;
        if (w_is_arp) begin
            if (r_in.arp_is_request && r_in.dst_ip == own_ip_in) begin
                n_out.action = ipv4fa_pkg::ActArpRep;
                n_out.tx_port = r_in.in_port;
                n_out.dst_mac_out = r_in.frame_src_mac;
                n_out.src_mac_out = own_mac_in;
                n_out.arp_sender_ip_out = own_ip_in;
                n_out.arp_target_ip_out = r_in.src_ip;
                n_out.arp_target_mac_out = r_in.arp_sender_mac;
            end else begin
                n_out.drop_reason = ipv4fa_pkg::DropArp;
            end
        end else if (!w_is_ip) begin
            n_out.drop_reason = ipv4fa_pkg::DropUnsupp;
        end else if (!w_route_ok) begin
            n_out.drop_reason = ipv4fa_pkg::DropNoRoute;
        end else if (w_op == r_in.in_port) begin
            n_out.drop_reason = ipv4fa_pkg::DropHairpin;
        end else if (!w_tok_out[w_op].hit) begin
            n_out.action = ipv4fa_pkg::ActArpReq;
            n_out.tx_port = w_op;
            n_out.dst_mac_out = '1;
            n_out.src_mac_out = own_mac_op;
            n_out.arp_sender_ip_out = own_ip_op;
            n_out.arp_target_ip_out = w_nh_ip;
        end else if (r_in.ttl <= 8'd1) begin
            n_out.drop_reason = ipv4fa_pkg::DropTtl;
        end else begin
            n_out.action = ipv4fa_pkg::ActForward;
            n_out.tx_port = w_op;
            n_out.dst_mac_out = w_tok_out[w_op].look_mac;
            n_out.src_mac_out = own_mac_op;
            n_out.ttl_out = r_in.ttl - 8'd1;
            n_out.checksum_out = w_ck;
        end
    end

    // Sequencer: accept, learn, look up, present.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipv4fa_pkg::StIdle:  if (i_in_valid) n_state = ipv4fa_pkg::StLearn;
            ipv4fa_pkg::StLearn: n_state = ipv4fa_pkg::StLook;
            ipv4fa_pkg::StLook:  n_state = ipv4fa_pkg::StOut;
            ipv4fa_pkg::StOut:   if (!i_out_stall) n_state = ipv4fa_pkg::StIdle;
            default:             n_state = ipv4fa_pkg::StIdle;
        endcase
    end

    always_comb begin
        o_in_stall  = r_state != ipv4fa_pkg::StIdle;
        o_out_valid = r_state == ipv4fa_pkg::StOut;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4fa_pkg::StIdle;
        end else begin
            r_state <= n_state;
        end
        if (r_state == ipv4fa_pkg::StIdle && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (r_state == ipv4fa_pkg::StLook) begin
            r_out <= n_out;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ipv4fa_pkg::StLearn |=> r_state == ipv4fa_pkg::StLook)
        else $error("lookup did not follow learn");
endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-port IPv4 forwarding block with address
// cache. Headers are driven with random gaps, results are checked in order
// against a predictor that keeps its own copy of the cache and registers.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: holds the router's expected decisions in arrival order.
    class route_scoreboard;
        ipv4fa_pkg::t_out_beat pending[$];
        int        errors;

        function void note_header(ipv4fa_pkg::t_out_beat exp_beat);
            pending.push_back(exp_beat);
        endfunction

        task check_result(ipv4fa_pkg::t_out_beat got);
            ipv4fa_pkg::t_out_beat exp_beat;
            if (pending.size() == 0) begin
                report_mismatch("result beat with nothing expected", 64'(0),
                                64'(got.action));
                return;
            end
            exp_beat = pending.pop_front();
            if (got.action != exp_beat.action)
                report_mismatch("action", 64'(exp_beat.action), 64'(got.action));
            if (got.drop_reason != exp_beat.drop_reason)
                report_mismatch("drop_reason", 64'(exp_beat.drop_reason),
                                64'(got.drop_reason));
            if (got.tx_port != exp_beat.tx_port)
                report_mismatch("tx_port", 64'(exp_beat.tx_port), 64'(got.tx_port));
            if (got.dst_mac_out != exp_beat.dst_mac_out)
                report_mismatch("dst_mac_out", 64'(exp_beat.dst_mac_out),
                                64'(got.dst_mac_out));
            if (got.src_mac_out != exp_beat.src_mac_out)
                report_mismatch("src_mac_out", 64'(exp_beat.src_mac_out),
                                64'(got.src_mac_out));
            if (got.arp_sender_ip_out != exp_beat.arp_sender_ip_out)
                report_mismatch("arp_sender_ip_out", 64'(exp_beat.arp_sender_ip_out),
                                64'(got.arp_sender_ip_out));
            if (got.arp_target_ip_out != exp_beat.arp_target_ip_out)
                report_mismatch("arp_target_ip_out", 64'(exp_beat.arp_target_ip_out),
                                64'(got.arp_target_ip_out));
            if (got.arp_target_mac_out != exp_beat.arp_target_mac_out)
                report_mismatch("arp_target_mac_out", 64'(exp_beat.arp_target_mac_out),
                                64'(got.arp_target_mac_out));
            if (got.ttl_out != exp_beat.ttl_out)
                report_mismatch("ttl_out", 64'(exp_beat.ttl_out), 64'(got.ttl_out));
            if (got.checksum_out != exp_beat.checksum_out)
                report_mismatch("checksum_out", 64'(exp_beat.checksum_out),
                                64'(got.checksum_out));
        endtask

        task report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
            errors++;
            $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
        endtask
    endclass

    localparam int WatchdogLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    ipv4fa_pkg::t_in_beat    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    ipv4fa_pkg::t_out_beat   out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    // Idle rates in percent; changed by the stimulus between and within phases.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;   // forces a long receiver hold-off
    int          idle_cycles = 0;
    int          sent_count = 0;
    bit          stimulus_done = 1'b0;

    // Predictor copies of registers and cache.
    logic [31:0] own_ip[2];
    logic [31:0] own_mask[2];
    logic [47:0] own_mac[2];
    logic [1:0]  default_route;
    logic [31:0] gateway_ip;
    bit          cache_valid[2][ipv4fa_pkg::EntriesPerPort];
    logic [31:0] cache_ip[2][ipv4fa_pkg::EntriesPerPort];
    logic [47:0] cache_mac[2][ipv4fa_pkg::EntriesPerPort];

    // Pool of addresses so that learning and lookups hit each other often.
    logic [31:0] host_pool[24];

    route_scoreboard sb;

    always #10 i_clk = ~i_clk;

    ipv4_forward_arp_cache DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Learning: refresh a matching entry, else take the first free one, else
    // overwrite the port's first slot.
    function automatic void learn_host(bit port, logic [31:0] ip, logic [47:0] mac);
        int slot;
        slot = -1;
        for (int i = 0; i < ipv4fa_pkg::EntriesPerPort; i++) begin
            if (cache_valid[port][i] && cache_ip[port][i] == ip) begin
                cache_mac[port][i] = mac;
                return;
            end
            if (!cache_valid[port][i] && slot < 0) slot = i;
        end
        if (slot < 0) slot = 0;
        cache_valid[port][slot] = 1'b1;
        cache_ip[port][slot] = ip;
        cache_mac[port][slot] = mac;
    endfunction

    // Incremental checksum update for a TTL decrement of one.
    function automatic logic [15:0] checksum_after_hop(logic [15:0] hc);
        logic [16:0] s;
        s = {1'b0, ~hc} + 17'h0FEFF;
        s = {1'b0, s[15:0]} + {16'b0, s[16]};
        s = {1'b0, s[15:0]} + {16'b0, s[16]};
        return ~s[15:0];
    endfunction

    function automatic ipv4fa_pkg::t_out_beat route_header(ipv4fa_pkg::t_in_beat h);
        ipv4fa_pkg::t_out_beat r;
        bit        op;
        bit        hit;
        logic [31:0] nh_ip;
        logic [47:0] nh_mac;
        r = '0;
        hit = 1'b0;
        nh_mac = '0;
        if (h.frame_kind == ipv4fa_pkg::KindArp) begin
            learn_host(h.in_port, h.src_ip, h.arp_sender_mac);
            if (h.arp_is_request && h.dst_ip == own_ip[h.in_port]) begin
                r.action = ipv4fa_pkg::ActArpRep;
                r.tx_port = h.in_port;
                r.dst_mac_out = h.frame_src_mac;
                r.src_mac_out = own_mac[h.in_port];
                r.arp_sender_ip_out = own_ip[h.in_port];
                r.arp_target_ip_out = h.src_ip;
                r.arp_target_mac_out = h.arp_sender_mac;
            end else begin
                r.drop_reason = ipv4fa_pkg::DropArp;
            end
            return r;
        end
        if (h.frame_kind != ipv4fa_pkg::KindIpv4) begin
            r.drop_reason = ipv4fa_pkg::DropUnsupp;
            return r;
        end
        learn_host(h.in_port, h.src_ip, h.frame_src_mac);
        if ((h.dst_ip & own_mask[0]) == (own_ip[0] & own_mask[0])) begin
            op = 1'b0; nh_ip = h.dst_ip;
        end else if ((h.dst_ip & own_mask[1]) == (own_ip[1] & own_mask[1])) begin
            op = 1'b1; nh_ip = h.dst_ip;
        end else if (default_route == ipv4fa_pkg::RouteP0 ||
                     default_route == ipv4fa_pkg::RouteP1) begin
            op = (default_route == ipv4fa_pkg::RouteP1); nh_ip = gateway_ip;
        end else begin
            r.drop_reason = ipv4fa_pkg::DropNoRoute;
            return r;
        end
        if (op == h.in_port) begin
            r.drop_reason = ipv4fa_pkg::DropHairpin;
            return r;
        end
        for (int i = 0; i < ipv4fa_pkg::EntriesPerPort; i++) begin
            if (!hit && cache_valid[op][i] && cache_ip[op][i] == nh_ip) begin
                hit = 1'b1;
                nh_mac = cache_mac[op][i];
            end
        end
        if (!hit) begin
            r.action = ipv4fa_pkg::ActArpReq;
            r.tx_port = op;
            r.dst_mac_out = '1;
            r.src_mac_out = own_mac[op];
            r.arp_sender_ip_out = own_ip[op];
            r.arp_target_ip_out = nh_ip;
            return r;
        end
        if (h.ttl <= 8'd1) begin
            r.drop_reason = ipv4fa_pkg::DropTtl;
            return r;
        end
        r.action = ipv4fa_pkg::ActForward;
        r.tx_port = op;
        r.dst_mac_out = nh_mac;
        r.src_mac_out = own_mac[op];
        r.ttl_out = h.ttl - 8'd1;
        r.checksum_out = checksum_after_hop(h.header_checksum);
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [47:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            ipv4fa_pkg::CfgPort0Addr: own_ip[0] = value[31:0];
            ipv4fa_pkg::CfgPort1Addr: own_ip[1] = value[31:0];
            ipv4fa_pkg::CfgPort0Mask: own_mask[0] = value[31:0];
            ipv4fa_pkg::CfgPort1Mask: own_mask[1] = value[31:0];
            ipv4fa_pkg::CfgPort0Mac:  own_mac[0] = value;
            ipv4fa_pkg::CfgPort1Mac:  own_mac[1] = value;
            ipv4fa_pkg::CfgDefRoute:  default_route = value[1:0];
            default:                  gateway_ip = value[31:0];
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one header beat, holding it until the block takes it.
    task automatic send_header(ipv4fa_pkg::t_in_beat h);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
            in_valid <= 1'b0;
        end
        @(posedge i_clk);
        in_valid <= 1'b1;
        in_data <= h;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        // The beat was taken at this edge; the next call decides on valid.
        sb.note_header(route_header(h));
        sent_count++;
        in_valid <= 1'b0;
    endtask

    // Waits until every result has come back plus the block's latency.
    task automatic drain;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_ip();
        if ($urandom_range(99) < 80) return host_pool[5'($urandom_range(23))];
        return $urandom();
    endfunction

    function automatic logic [47:0] rand_mac();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly well-formed ARP and IPv4 headers with addresses from the pool.
    function automatic ipv4fa_pkg::t_in_beat random_header();
        ipv4fa_pkg::t_in_beat h;
        int k;
        k = $urandom_range(99);
        h.in_port = 1'($urandom_range(1));
        h.frame_kind = k < 35 ? ipv4fa_pkg::KindArp :
                       (k < 92 ? ipv4fa_pkg::KindIpv4 : 2'($urandom_range(2, 3)));
        h.arp_is_request = 1'($urandom_range(1));
        h.src_ip = pick_ip();
        h.dst_ip = ($urandom_range(99) < 20) ? own_ip[1'($urandom_range(1))] : pick_ip();
        h.frame_src_mac = rand_mac();
        h.arp_sender_mac = rand_mac();
        h.ttl = ($urandom_range(9) == 0) ? 8'($urandom_range(1)) : 8'($urandom());
        h.header_checksum = 16'($urandom());
        return h;
    endfunction

    task automatic configure_ports(logic [31:0] a0, logic [31:0] a1, logic [31:0] m0,
                                   logic [31:0] m1, logic [1:0] route);
        write_reg(ipv4fa_pkg::CfgPort0Addr, {16'h0, a0});
        write_reg(ipv4fa_pkg::CfgPort1Addr, {16'h0, a1});
        write_reg(ipv4fa_pkg::CfgPort0Mask, {16'h0, m0});
        write_reg(ipv4fa_pkg::CfgPort1Mask, {16'h0, m1});
        write_reg(ipv4fa_pkg::CfgPort0Mac, rand_mac());
        write_reg(ipv4fa_pkg::CfgPort1Mac, rand_mac());
        write_reg(ipv4fa_pkg::CfgDefRoute, {46'h0, route});
        write_reg(ipv4fa_pkg::CfgGateway, {16'h0, host_pool[5'($urandom_range(23))]});
    endtask

    task automatic build_pool(logic [31:0] a0, logic [31:0] a1);
        for (int i = 0; i < 24; i++) begin
            case (i % 3)
                0: host_pool[i] = {a0[31:8], 8'($urandom())};
                1: host_pool[i] = {a1[31:8], 8'($urandom())};
                default: host_pool[i] = $urandom();
            endcase
        end
    endtask

    // Result side: samples at the edge, draws a new stall nonblocking.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) sb.check_result(out_data);
        if (recv_hold)
            out_stall <= 1'b1;
        else
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Timeout after %0d quiet cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Holds the receiver off for a long stretch while headers keep coming.
    task automatic hold_receiver;
        int n;
        recv_hold = 1'b1;
        n = 0;
        while (n < 300) begin
            @(posedge i_clk);
            n++;
        end
        recv_hold = 1'b0;
    endtask

    initial begin
        ipv4fa_pkg::t_in_beat h;
        logic [31:0] a0, a1;
        sb = new();
        own_ip = '{default: '0};
        own_mask = '{default: 32'hFFFFFF00};
        own_mac = '{default: '0};
        default_route = '0;
        gateway_ip = '0;
        cache_valid = '{default: '0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset register values.
        a0 = 32'h0A000001;
        a1 = 32'hC0A80101;
        build_pool(a0, a1);
        h = '0;
        send_header(h);                 // ARP reply from all-zero sender, dropped
        h.frame_kind = ipv4fa_pkg::KindOther;   // unsupported kinds
        send_header(h);
        h.frame_kind = ipv4fa_pkg::KindRsvd;
        send_header(h);
        h.frame_kind = ipv4fa_pkg::KindIpv4;    // target in port 0 subnet, arrived on 0
        h.dst_ip = 32'h00000005;
        send_header(h);
        drain();

        configure_ports(a0, a1, 32'hFFFFFF00, 32'hFFFF0000, ipv4fa_pkg::RouteP1);
        h = '0;
        h.in_port = 1'b1;               // ARP request for port 1's own address
        h.arp_is_request = 1'b1;
        h.src_ip = 32'hC0A80177;
        h.dst_ip = a1;
        h.frame_src_mac = '1;
        h.arp_sender_mac = 48'hFFFF_FFFF_FFFF;
        send_header(h);
        h.arp_is_request = 1'b0;        // ARP reply, consumed
        send_header(h);
        h.arp_is_request = 1'b1;        // request for another address
        h.dst_ip = 32'hFFFFFFFF;
        send_header(h);
        h = '0;                         // IPv4 from port 1 to port 0 subnet: miss
        h.in_port = 1'b1;
        h.frame_kind = ipv4fa_pkg::KindIpv4;
        h.src_ip = 32'hC0A80177;
        h.dst_ip = 32'h0A000042;
        h.ttl = 8'hFF;
        h.header_checksum = 16'hFFFF;
        send_header(h);
        h.in_port = 1'b0;               // teach port 0 the host
        h.src_ip = 32'h0A000042;
        h.dst_ip = 32'hC0A80177;        // and forward it to port 1 (learned above)
        h.frame_src_mac = 48'h0123_4567_89AB;
        h.header_checksum = 16'h0000;
        send_header(h);
        h.in_port = 1'b1;               // now a hit towards port 0
        h.src_ip = 32'hC0A80177;
        h.dst_ip = 32'h0A000042;
        h.ttl = 8'd2;
        h.header_checksum = 16'h1234;
        send_header(h);
        h.ttl = 8'd1;                   // expired TTL
        send_header(h);
        h.ttl = 8'd0;
        send_header(h);
        h.in_port = 1'b0;               // hairpin
        send_header(h);
        h.dst_ip = 32'h08080808;        // default route towards port 1
        send_header(h);
        // Eighteen distinct senders on port 0 overflow its cache.
        for (int i = 0; i < 18; i++) begin
            h = '0;
            h.src_ip = 32'h0A000100 + 32'(i);
            h.arp_sender_mac = rand_mac();
            send_header(h);
        end
        drain();

        // Random phases across several register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            a0 = (phase == 1) ? 32'h0 : (phase == 2 ? 32'hFFFFFFFF : $urandom());
            a1 = (phase == 1) ? 32'hFFFFFFFF : $urandom();
            build_pool(a0, a1);
            configure_ports(a0, a1,
                            phase == 1 ? 32'h0 : (phase == 2 ? 32'hFFFFFFFF : 32'hFFFFFF00),
                            phase == 3 ? 32'hFFFFFFFF : 32'hFFFFFF00,
                            2'(phase % 4));
            send_idle_pct = (phase < 2) ? 21 : (phase < 4 ? 86 : 0);
            recv_idle_pct = (phase < 2) ? 86 : (phase < 4 ? 21 : 0);
            if (phase == 4) begin
                fork
                    hold_receiver();
                    for (int i = 0; i < 40; i++) send_header(random_header());
                join
            end
            for (int i = 0; i < 130; i++) begin
                send_header(random_header());
                // Stretches with neither side idling.
                if (i == 65 && phase < 4) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            end
            drain();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
